// ===== design/crc8fe_pkg.sv =====
// ----------------------------------------------------------------------------
// crc8fe_pkg
// Types, codes and the CRC-8 step shared by the SPI register frame engine.
// ----------------------------------------------------------------------------
package crc8fe_pkg;

   // Command codes on the request channel
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_RX    = 1'b1;

   // Request kinds
   localparam logic [1:0] KIND_STATUS  = 2'd0;
   localparam logic [1:0] KIND_WRITE   = 2'd1;
   localparam logic [1:0] KIND_READ    = 2'd2;
   localparam logic [1:0] KIND_INVALID = 2'd3;

   // Result kinds
   localparam logic OUT_FRAME = 1'b0;
   localparam logic OUT_DONE  = 1'b1;

   // Error codes
   localparam logic [1:0] ERR_NONE = 2'd0;
   localparam logic [1:0] ERR_ACK  = 2'd1;
   localparam logic [1:0] ERR_CRC  = 2'd2;
   localparam logic [1:0] ERR_RSVD = 2'd3;

   // Configuration register indexes
   localparam logic [1:0] CSR_OPC_STATUS = 2'd0;
   localparam logic [1:0] CSR_OPC_WRITE  = 2'd1;
   localparam logic [1:0] CSR_OPC_READ   = 2'd2;
   localparam logic [1:0] CSR_ACK        = 2'd3;

   localparam logic [7:0] OPC_STATUS_RESET = 8'hF0;
   localparam logic [7:0] OPC_WRITE_RESET  = 8'hF2;
   localparam logic [7:0] OPC_READ_RESET   = 8'hF4;
   localparam logic [7:0] ACK_RESET        = 8'hA5;

   localparam logic [7:0] CRC_POLY = 8'h07;

   // Index of the last byte of a frame (status frames are 4 bytes, others 8)
   localparam logic [2:0] STATUS_LAST_IDX = 3'd3;
   localparam logic [2:0] LONG_LAST_IDX   = 3'd7;

   // Received bytes kept: 0..6 (the acknowledge byte is taken on arrival)
   localparam int RX_KEEP = 7;

   typedef struct packed {
      logic        cmd;
      logic [1:0]  request_kind;
      logic [7:0]  reg_address;
      logic [31:0] write_word;
      logic [7:0]  rx_byte;
   } req_item_type;

   typedef struct packed {
      logic        out_kind;
      logic [7:0]  tx_byte;
      logic        last;
      logic [15:0] status_word;
      logic [31:0] read_word;
      logic [1:0]  error_code;
      logic [7:0]  ack_seen;
   } rsp_item_type;

   // Work handed from the front to the back: either a frame to send or a
   // finished transaction to report
   typedef struct packed {
      logic        is_done;
      logic [1:0]  frame_kind;
      logic [7:0]  opcode;
      logic [7:0]  address;
      logic [31:0] word;
      logic [15:0] status_word;
      logic [31:0] read_word;
      logic [1:0]  error_code;
      logic [7:0]  ack_seen;
   } job_type;

   // One byte through the CRC-8 (poly 0x07, MSB first)
   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] v;
      v = crc ^ data;
      for (int b = 0; b < 8; b++) begin
         v = v[7] ? ({v[6:0], 1'b0} ^ CRC_POLY) : {v[6:0], 1'b0};
      end
      return v;
   endfunction

endpackage

// ===== design/crc8_spi_register_frame_engine_unit.sv =====
// ----------------------------------------------------------------------------
// crc8_spi_register_frame_engine_unit
// Host-side framer and checker for a CRC-8 protected SPI register protocol.
// ----------------------------------------------------------------------------
//
//  channel | ports                              | transfer when
//  --------+------------------------------------+---------------------------
//  request | push, full, req_item               | push && !full
//  result  | pop, empty, rsp_item               | pop && !empty
//  csr     | csr_write_enable, csr_index, data  | csr_write_enable
//
// A start request yields 4 (status) or 8 (write/read) frame-byte results, one
// per cycle while the result queue has room, set by the byte emitter in the
// back stage; a received byte is taken by the front and the last one yields a
// single completion report. Requests are taken every cycle while the job queue
// has room, so the front keeps taking input while the back is still emitting an
// earlier frame. Reset is synchronous, active high, and returns to idle with
// the register defaults; a stalled result side holds the back, which in turn
// fills the queue.
module crc8_spi_register_frame_engine_unit
   import crc8fe_pkg::*;
#(
   parameter int JOB_DEPTH = 4,
   parameter int RSP_DEPTH = 2
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   output logic         full,
   input  req_item_type req_item,
   input  logic         pop,
   output logic         empty,
   output rsp_item_type rsp_item,
   input  logic         csr_write_enable,
   input  logic [1:0]   csr_index,
   input  logic [7:0]   csr_write_data
);

   logic         accept;
   logic         job_push;
   job_type      job_wr;
   logic         job_full;
   logic         job_empty;
   job_type      job_rd;
   logic         job_pop;
   logic         rsp_push;
   logic         rsp_full;
   rsp_item_type rsp_wr;

   // take the next item whenever the job queue has room
   assign full   = job_full;
   assign accept = push && !job_full;

   crc8fe_front u_front (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .item             (req_item),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .job_push         (job_push),
      .job              (job_wr)
   );

   // decouple classification from emission
   crc8fe_fifo #(
      .item_type (job_type),
      .DEPTH     (JOB_DEPTH)
   ) u_job_q (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (job_push),
      .wr_data (job_wr),
      .full    (job_full),
      .rd_en   (job_pop),
      .rd_data (job_rd),
      .empty   (job_empty)
   );

   crc8fe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_empty (job_empty),
      .job       (job_rd),
      .job_pop   (job_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp       (rsp_wr)
   );

   // hold finished results until the consumer takes them
   crc8fe_fifo #(
      .item_type (rsp_item_type),
      .DEPTH     (RSP_DEPTH)
   ) u_rsp_q (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (rsp_push),
      .wr_data (rsp_wr),
      .full    (rsp_full),
      .rd_en   (pop),
      .rd_data (rsp_item),
      .empty   (empty)
   );

`ifndef SYNTHESIS
   a_job_no_overflow: assert property (@(posedge clock) disable iff (reset)
      job_push |-> !job_full)
      else $error("job queue written while full");

   a_invalid_kind_dropped: assert property (@(posedge clock) disable iff (reset)
      (accept && req_item.cmd == CMD_START && req_item.request_kind == KIND_INVALID)
      |-> !job_push)
      else $error("unknown request kind produced work");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_item.out_kind == OUT_DONE) |-> rsp_item.last)
      else $error("completion report not flagged last");

   a_error_code_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_push && rsp_wr.out_kind == OUT_DONE) |-> rsp_wr.error_code != ERR_RSVD)
      else $error("reserved error code emitted");
`endif

endmodule

// ===== design/crc8fe_fifo.sv =====
// ----------------------------------------------------------------------------
// crc8fe_fifo
// Small synchronous queue used between the engine's stages.
// ----------------------------------------------------------------------------
module crc8fe_fifo #(
   parameter type item_type = logic,
   parameter int  DEPTH     = 4
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     wr_en,
   input  item_type wr_data,
   output logic     full,
   input  logic     rd_en,
   output item_type rd_data,
   output logic     empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   item_type         mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr, do_rd;

   assign full    = (count_ff == FULL_CNT);
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ===== design/crc8fe_front.sv =====
// ----------------------------------------------------------------------------
// crc8fe_front
// Accepts requests and received bytes, holds the configuration registers,
// stores the incoming frame and checks it as it arrives.
// ----------------------------------------------------------------------------
module crc8fe_front
   import crc8fe_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  req_item_type item,
   input  logic         csr_write_enable,
   input  logic [1:0]   csr_index,
   input  logic [7:0]   csr_write_data,
   output logic         job_push,
   output job_type      job
);

   logic [7:0] opc_status_ff, opc_write_ff, opc_read_ff, ack_exp_ff;
   logic       busy_ff, busy_in;
   logic [1:0] kind_ff, kind_in;
   logic [2:0] count_ff, count_in;
   logic [7:0] crc_ff, crc_in;
   logic [7:0] frame_ff [RX_KEEP];
   logic       store_en;
   logic [2:0] last_idx;
   logic       in_crc_span;
   logic [7:0] crc_byte;

   assign last_idx    = (kind_ff == KIND_STATUS) ? STATUS_LAST_IDX : LONG_LAST_IDX;
   assign in_crc_span = (kind_ff == KIND_READ) ? (count_ff < 3'd6) : (count_ff < 3'd2);
   assign crc_byte    = (kind_ff == KIND_READ) ? frame_ff[6] : frame_ff[2];
   assign store_en    = accept && item.cmd == CMD_RX && busy_ff
                        && count_ff < 3'(RX_KEEP);

   always_comb begin
      busy_in  = busy_ff;
      kind_in  = kind_ff;
      count_in = count_ff;
      crc_in   = crc_ff;
      job_push = 1'b0;
      job      = '0;
      if (accept) begin
         if (item.cmd == CMD_START) begin
            // drop unknown kinds; otherwise (re)start the transaction
            if (item.request_kind != KIND_INVALID) begin
               busy_in        = 1'b1;
               kind_in        = item.request_kind;
               count_in       = '0;
               crc_in         = '0;
               job_push       = 1'b1;
               job.is_done    = 1'b0;
               job.frame_kind = item.request_kind;
               job.address    = item.reg_address;
               job.word       = item.write_word;
               unique case (item.request_kind)
                  KIND_STATUS: job.opcode = opc_status_ff;
                  KIND_WRITE:  job.opcode = opc_write_ff;
                  default:     job.opcode = opc_read_ff;
               endcase
            end
         end else if (busy_ff) begin
            count_in = count_ff + 1'b1;
            if (in_crc_span) begin
               crc_in = crc8_update(crc_ff, item.rx_byte);
            end
            if (count_ff == last_idx) begin
               // last byte is the acknowledge: report the transaction
               busy_in         = 1'b0;
               count_in        = '0;
               job_push        = 1'b1;
               job.is_done     = 1'b1;
               job.frame_kind  = kind_ff;
               job.status_word = {frame_ff[0], frame_ff[1]};
               job.ack_seen    = item.rx_byte;
               if (item.rx_byte != ack_exp_ff) begin
                  job.error_code = ERR_ACK;
               end else if (crc_ff != crc_byte) begin
                  job.error_code = ERR_CRC;
               end else begin
                  job.error_code = ERR_NONE;
               end
               if (job.error_code == ERR_NONE && kind_ff == KIND_READ) begin
                  job.read_word = {frame_ff[2], frame_ff[3], frame_ff[4], frame_ff[5]};
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         opc_status_ff <= OPC_STATUS_RESET;
         opc_write_ff  <= OPC_WRITE_RESET;
         opc_read_ff   <= OPC_READ_RESET;
         ack_exp_ff    <= ACK_RESET;
         busy_ff       <= 1'b0;
         kind_ff       <= KIND_STATUS;
         count_ff      <= '0;
         crc_ff        <= '0;
      end else begin
         busy_ff  <= busy_in;
         kind_ff  <= kind_in;
         count_ff <= count_in;
         crc_ff   <= crc_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_OPC_STATUS: opc_status_ff <= csr_write_data;
               CSR_OPC_WRITE:  opc_write_ff  <= csr_write_data;
               CSR_OPC_READ:   opc_read_ff   <= csr_write_data;
               CSR_ACK:        ack_exp_ff    <= csr_write_data;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (store_en) begin
         frame_ff[count_ff] <= item.rx_byte;
      end
   end

endmodule

// ===== design/crc8fe_back.sv =====
// ----------------------------------------------------------------------------
// crc8fe_back
// Takes jobs from the queue and turns them into result items: one per frame
// byte, with the CRC built byte by byte, or one completion report.
// ----------------------------------------------------------------------------
module crc8fe_back
   import crc8fe_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         job_empty,
   input  job_type      job,
   output logic         job_pop,
   input  logic         rsp_full,
   output logic         rsp_push,
   output rsp_item_type rsp
);

   logic       active_ff, active_in;
   job_type    cur_ff;
   logic [2:0] idx_ff, idx_in;
   logic [7:0] crc_ff, crc_in;
   logic [7:0] byte_sel;
   logic [2:0] last_idx;
   logic       is_last;
   logic       is_write;

   assign is_write = (cur_ff.frame_kind == KIND_WRITE);
   assign last_idx = (cur_ff.frame_kind == KIND_STATUS) ? STATUS_LAST_IDX : LONG_LAST_IDX;
   assign is_last  = cur_ff.is_done || (idx_ff == last_idx);
   assign rsp_push = active_ff && !rsp_full;
   assign job_pop  = !job_empty && (!active_ff || (rsp_push && is_last));

   always_comb begin
      unique case (idx_ff)
         3'd0:    byte_sel = cur_ff.opcode;
         3'd1:    byte_sel = cur_ff.address;
         3'd2:    byte_sel = is_write ? cur_ff.word[31:24] : crc_ff;
         3'd3:    byte_sel = is_write ? cur_ff.word[23:16] : 8'h00;
         3'd4:    byte_sel = is_write ? cur_ff.word[15:8]  : 8'h00;
         3'd5:    byte_sel = is_write ? cur_ff.word[7:0]   : 8'h00;
         3'd6:    byte_sel = is_write ? crc_ff : 8'h00;
         default: byte_sel = 8'h00;
      endcase
   end

   always_comb begin
      rsp = '0;
      if (cur_ff.is_done) begin
         rsp.out_kind    = OUT_DONE;
         rsp.last        = 1'b1;
         rsp.status_word = cur_ff.status_word;
         rsp.read_word   = cur_ff.read_word;
         rsp.error_code  = cur_ff.error_code;
         rsp.ack_seen    = cur_ff.ack_seen;
      end else begin
         rsp.out_kind = OUT_FRAME;
         rsp.tx_byte  = byte_sel;
         rsp.last     = is_last;
      end
   end

   always_comb begin
      active_in = active_ff;
      idx_in    = idx_ff;
      crc_in    = crc_ff;
      if (rsp_push) begin
         idx_in = idx_ff + 1'b1;
         crc_in = crc8_update(crc_ff, byte_sel);
         if (is_last) begin
            active_in = 1'b0;
         end
      end
      if (job_pop) begin
         active_in = 1'b1;
         idx_in    = '0;
         crc_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         idx_ff    <= '0;
         crc_ff    <= '0;
      end else begin
         active_ff <= active_in;
         idx_ff    <= idx_in;
         crc_ff    <= crc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (job_pop) begin
         cur_ff <= job;
      end
   end

endmodule
